// ===== src/swm_pkg.sv =====
// Package for the sliding-window median filter.
// Holds default sizes, the register map and the window register width.
// No dependencies.
package swm_pkg;

   localparam int WINDOW_MAX_DEF   = 16;
   localparam int SAMPLE_WIDTH_DEF = 16;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   localparam int WSIZE_W    = 5;

   localparam logic [WSIZE_W-1:0] WINDOW_SIZE_RESET = WSIZE_W'(3);

   // register index = byte address / 4
   localparam logic [CSR_ADDR_W-3:0] REG_WINDOW_SIZE = '0;

endpackage

// ===== src/sliding_window_median.sv =====
// Sliding-window median filter, top level.
// Depends on swm_pkg for default sizes and the register map.
// A user of the block should know this first: one sample is taken per clock cycle and the
// result, twice the median of the last window_size samples, appears in the output register
// one cycle after the sample that completes or slides a full window. Samples that only fill
// the window give no result. The whole sorted window is held in flip-flops and updated in one
// cycle by a parallel compare-and-shift over all entries, which sets the cycle time. Input
// stall is raised only while a result waits and the output is stalled. Writing window_size
// (byte address 0) or a sample with restart set empties the window; sizes 0 and above
// WINDOW_MAX act as 1 and WINDOW_MAX.
module sliding_window_median
   import swm_pkg::*;
#(
   parameter int WINDOW_MAX   = WINDOW_MAX_DEF,
   parameter int SAMPLE_WIDTH = SAMPLE_WIDTH_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   // sample channel
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0] req_sample,
   input  logic                           req_restart,
   // result channel
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [SAMPLE_WIDTH:0]   rsp_median_twice,
   // register port
   input  logic                           csr_psel,
   input  logic                           csr_penable,
   input  logic                           csr_pwrite,
   input  logic [CSR_ADDR_W-1:0]          csr_paddr,
   input  logic [CSR_DATA_W-1:0]          csr_pwdata,
   output logic [CSR_DATA_W-1:0]          csr_prdata,
   output logic                           csr_pready
);

   localparam int CNT_W = $clog2(WINDOW_MAX + 1);
   localparam int IDX_W = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
   localparam int SW    = SAMPLE_WIDTH;

   logic [WSIZE_W-1:0]    window_size_ff, window_size_in;
   logic [CNT_W-1:0]      fill_ff, fill_in;
   logic [IDX_W-1:0]      ptr_ff, ptr_in;
   logic signed [SW-1:0]  ring_ff   [WINDOW_MAX];
   logic signed [SW-1:0]  sorted_ff [WINDOW_MAX];
   logic signed [SW-1:0]  sorted_in [WINDOW_MAX];
   logic                  rsp_valid_ff, rsp_valid_in;
   logic signed [SW:0]    median_ff, median_in;

   logic                  csr_wr;
   logic                  req_take;
   logic [CNT_W-1:0]      eff_w;
   logic                  clr;
   logic [CNT_W-1:0]      n;
   logic [IDX_W-1:0]      p;
   logic                  full;
   logic signed [SW-1:0]  old;
   logic [IDX_W-1:0]      wr_idx;
   logic [CNT_W-1:0]      cnt;
   logic                  res_valid;
   logic signed [SW-1:0]  rem     [WINDOW_MAX];
   logic                  below   [WINDOW_MAX];
   logic [IDX_W-1:0]      lo_idx, hi_idx;
   logic signed [SW-1:0]  lo_val, hi_val;

   // ---------------- register port ----------------
   assign csr_pready = 1'b1;
   assign csr_wr = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                   (csr_paddr[CSR_ADDR_W-1:2] == REG_WINDOW_SIZE);

   always_comb begin
      csr_prdata = '0;
      if (csr_paddr[CSR_ADDR_W-1:2] == REG_WINDOW_SIZE) begin
         csr_prdata = CSR_DATA_W'(window_size_ff);
      end
   end

   always_comb begin
      window_size_in = window_size_ff;
      if (csr_wr) begin
         window_size_in = csr_pwdata[WSIZE_W-1:0];
      end
   end

   // zero acts as one, oversize saturates
   always_comb begin
      if (window_size_ff == '0) begin
         eff_w = CNT_W'(1);
      end else if (32'(window_size_ff) > WINDOW_MAX) begin
         eff_w = CNT_W'(WINDOW_MAX);
      end else begin
         eff_w = CNT_W'(window_size_ff);
      end
   end

   // ---------------- handshake ----------------
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign req_take  = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_median_twice = median_ff;

   // ---------------- window update ----------------
   always_comb begin
      clr    = req_restart || (fill_ff > eff_w) || (CNT_W'(ptr_ff) >= eff_w);
      n      = clr ? '0 : fill_ff;
      p      = clr ? '0 : ptr_ff;
      full   = (n == eff_w);
      old    = ring_ff[p];
      wr_idx = full ? p : n[IDX_W-1:0];
      cnt    = full ? (n - CNT_W'(1)) : n;
      res_valid = full || ((n + CNT_W'(1)) == eff_w);

      if (full) begin
         fill_in = n;
         ptr_in  = ((CNT_W'(p) + CNT_W'(1)) >= eff_w) ? '0 : (p + IDX_W'(1));
      end else begin
         fill_in = n + CNT_W'(1);
         ptr_in  = '0;
      end
   end

   // Remove the leaving sample: entries at or past its first copy shift down one.
   // Then insert the new sample at the first entry greater than it.
   always_comb begin
      for (int i = 0; i < WINDOW_MAX; i++) begin
         rem[i] = sorted_ff[i];
         if (full && !(sorted_ff[i] < old) && (i < WINDOW_MAX - 1)) begin
            rem[i] = sorted_ff[(i < WINDOW_MAX - 1) ? i + 1 : i];
         end
      end
      for (int i = 0; i < WINDOW_MAX; i++) begin
         below[i] = (CNT_W'(i) < cnt) && (rem[i] <= req_sample);
      end
      for (int j = 0; j < WINDOW_MAX; j++) begin
         if (below[j]) begin
            sorted_in[j] = rem[j];
         end else if (j == 0) begin
            sorted_in[j] = req_sample;
         end else if (below[(j > 0) ? j - 1 : 0]) begin
            sorted_in[j] = req_sample;
         end else begin
            sorted_in[j] = rem[(j > 0) ? j - 1 : 0];
         end
      end
   end

   // middle pair; equal indices for an odd window
   always_comb begin
      lo_idx    = IDX_W'((eff_w - CNT_W'(1)) >> 1);
      hi_idx    = IDX_W'(eff_w >> 1);
      lo_val    = sorted_in[lo_idx];
      hi_val    = sorted_in[hi_idx];
      median_in = {lo_val[SW-1], lo_val} + {hi_val[SW-1], hi_val};
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (req_take) begin
         rsp_valid_in = res_valid;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // ---------------- registers ----------------
   always_ff @(posedge clock) begin
      if (reset) begin
         window_size_ff <= WINDOW_SIZE_RESET;
         fill_ff        <= '0;
         ptr_ff         <= '0;
         rsp_valid_ff   <= 1'b0;
      end else begin
         window_size_ff <= window_size_in;
         rsp_valid_ff   <= rsp_valid_in;
         if (csr_wr) begin
            fill_ff <= '0;
            ptr_ff  <= '0;
         end else if (req_take) begin
            fill_ff <= fill_in;
            ptr_ff  <= ptr_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && !csr_wr) begin
         ring_ff[wr_idx] <= req_sample;
         for (int i = 0; i < WINDOW_MAX; i++) begin
            sorted_ff[i] <= sorted_in[i];
         end
      end
      if (req_take && res_valid) begin
         median_ff <= median_in;
      end
   end

   // ---------------- assertions ----------------
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= eff_w)
      else $error("fill count beyond window size");

   a_full_gives_result: assert property (@(posedge clock) disable iff (reset)
      req_take && !csr_wr && full |=> rsp_valid_ff)
      else $error("full window transaction produced no result");

   a_odd_even_result: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && eff_w[0] |-> !median_ff[0])
      else $error("odd window result is not twice a sample");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for sliding_window_median: random and directed samples, window-size
// writes over the register port, and a scoreboard class that tracks the window and its median.
// Depends on swm_pkg and the sliding_window_median RTL.
`timescale 1ns / 1ps

module testbench;
   import swm_pkg::*;

   localparam int WMAX         = WINDOW_MAX_DEF;
   localparam int SW           = SAMPLE_WIDTH_DEF;
   localparam int REG_UNMAPPED = 1;      // byte address 4, nothing lives there
   localparam int SETTLE_CYC   = 4;

   logic                 clock;
   logic                 reset;
   logic                 req_valid;
   logic                 req_stall;
   logic signed [SW-1:0] req_sample;
   logic                 req_restart;
   logic                 rsp_valid;
   logic                 rsp_stall;
   logic signed [SW:0]   rsp_median_twice;
   logic                 csr_psel;
   logic                 csr_penable;
   logic                 csr_pwrite;
   logic [CSR_ADDR_W-1:0] csr_paddr;
   logic [CSR_DATA_W-1:0] csr_pwdata;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                 csr_pready;

   int send_idle_pct;
   int stall_pct;
   int window_writes;

   sliding_window_median dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_sample       (req_sample),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_median_twice (rsp_median_twice),
      .csr_psel         (csr_psel),
      .csr_penable      (csr_penable),
      .csr_pwrite       (csr_pwrite),
      .csr_paddr        (csr_paddr),
      .csr_pwdata       (csr_pwdata),
      .csr_prdata       (csr_prdata),
      .csr_pready       (csr_pready)
   );

   // Tracks the window in arrival order and sorted, and queues the medians it predicts.
   class median_tracker;
      logic [WSIZE_W-1:0]   wsize;
      logic signed [SW-1:0] arrivals [WMAX];
      logic signed [SW-1:0] ordered [WMAX];
      int                   oldest_slot;
      int                   held;
      logic signed [SW:0]   pending_medians [$];
      int                   errors;
      int                   samples;
      int                   medians;

      function new();
         wsize       = WINDOW_SIZE_RESET;
         oldest_slot = 0;
         held        = 0;
         errors      = 0;
         samples     = 0;
         medians     = 0;
         for (int i = 0; i < WMAX; i++) begin
            arrivals[i] = '0;
            ordered[i]  = '0;
         end
      endfunction

      function void report_mismatch(string msg);
         $display("[%0t] MISMATCH: %s", $time, msg);
         errors++;
      endfunction

      function void set_window(logic [WSIZE_W-1:0] size);
         wsize       = size;
         held        = 0;
         oldest_slot = 0;
      endfunction

      function int span();
         if (wsize == 0)
            return 1;
         if (wsize > WMAX)
            return WMAX;
         return int'(wsize);
      endfunction

      function void note_sample(logic signed [SW-1:0] value, logic restart);
         int                 w;
         int                 n;
         int                 p;
         bit                 found;
         logic signed [SW-1:0] leaving;
         logic signed [SW:0] lo;
         logic signed [SW:0] hi;

         w = span();
         samples++;
         if (restart) begin
            held        = 0;
            oldest_slot = 0;
         end
         if (held > w || oldest_slot >= w) begin
            held        = 0;
            oldest_slot = 0;
         end
         n = held;
         if (n == w) begin
            // drop exactly one copy of the oldest sample
            leaving = arrivals[oldest_slot];
            found   = 0;
            for (int i = 0; i < n; i++) begin
               if (!found && ordered[i] == leaving)
                  found = 1;
               if (found && i + 1 < n)
                  ordered[i] = ordered[i+1];
            end
            if (found)
               n--;
         end
         p = 0;
         while (p < n && ordered[p] <= value)
            p++;
         for (int j = n; j > p; j--)
            ordered[j] = ordered[j-1];
         ordered[p] = value;
         if (held == w) begin
            arrivals[oldest_slot] = value;
            oldest_slot = (oldest_slot + 1 >= w) ? 0 : oldest_slot + 1;
         end else begin
            arrivals[held] = value;
            held           = held + 1;
            oldest_slot    = 0;
         end
         if (held != w)
            return;
         if (w % 2 == 1) begin
            lo = ordered[w/2];
            hi = ordered[w/2];
         end else begin
            lo = ordered[w/2-1];
            hi = ordered[w/2];
         end
         pending_medians.push_back(lo + hi);
      endfunction

      function void check_median(logic signed [SW:0] got);
         logic signed [SW:0] want;
         if (pending_medians.size() == 0) begin
            report_mismatch($sformatf("median_twice %0d with no transaction pending", got));
            return;
         end
         want = pending_medians.pop_front();
         medians++;
         if (got !== want)
            report_mismatch($sformatf("median_twice got %0d, want %0d", got, want));
      endfunction
   endclass

   median_tracker tracker;

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #20_000_000;
      $display("DONE: errors detected");
      $finish;
   end

   always @(posedge clock) begin
      if (reset)
         rsp_stall <= 1'b0;
      else
         rsp_stall <= ($urandom_range(99) < stall_pct);
   end

   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall)
            tracker.note_sample(req_sample, req_restart);
         if (rsp_valid && !rsp_stall)
            tracker.check_median(rsp_median_twice);
      end
   end

   task automatic send_sample(input logic signed [SW-1:0] value, input logic restart);
      logic held_off;
      // idle cycle by cycle so the idle share matches the percentage
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_sample  <= value;
      req_restart <= restart;
      do begin
         @(negedge clock);
         held_off = req_stall;
         @(posedge clock);
      end while (held_off);
   endtask

   // Drop valid and wait for every predicted median, then for the pipeline to empty.
   task automatic settle();
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (tracker.pending_medians.size() != 0 && guard < 5000) begin
         @(posedge clock);
         guard++;
      end
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic csr_write(input int idx, input logic [CSR_DATA_W-1:0] value);
      logic rdy;
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(idx * 4);
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy = csr_pready;
         @(posedge clock);
      end while (!rdy);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      if (idx == int'(REG_WINDOW_SIZE)) begin
         tracker.set_window(value[WSIZE_W-1:0]);
         window_writes++;
      end
   endtask

   task automatic csr_check_window();
      logic                  rdy;
      logic [CSR_DATA_W-1:0] got;
      // leave the bus idle after any preceding transfer
      @(posedge clock);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b0;
      csr_penable <= 1'b0;
      csr_paddr   <= CSR_ADDR_W'(int'(REG_WINDOW_SIZE) * 4);
      @(posedge clock);
      csr_penable <= 1'b1;
      do begin
         @(negedge clock);
         rdy = csr_pready;
         got = csr_prdata;
         @(posedge clock);
      end while (!rdy);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      if (got !== CSR_DATA_W'(tracker.wsize))
         tracker.report_mismatch($sformatf("window_size read %0d, want %0d",
                                           got, tracker.wsize));
   endtask

   task automatic set_window_size(input int size);
      logic [CSR_DATA_W-1:0] word;
      word = $urandom();
      word[WSIZE_W-1:0] = WSIZE_W'(size);
      settle();
      csr_write(int'(REG_WINDOW_SIZE), word);
      csr_check_window();
   endtask

   function automatic logic signed [SW-1:0] pick_sample();
      case ($urandom_range(9))
         0: return {1'b1, {(SW-1){1'b0}}};
         1: return {1'b0, {(SW-1){1'b1}}};
         2, 3, 4: return SW'(int'($urandom_range(6)) - 3);   // dense duplicates
         default: return SW'($urandom());
      endcase
   endfunction

   task automatic set_idle_mode(input int mode);
      case (mode % 4)
         0: begin send_idle_pct <= 0;  stall_pct <= 0;  end
         1: begin send_idle_pct <= 66; stall_pct <= 0;  end
         2: begin send_idle_pct <= 0;  stall_pct <= 66; end
         default: begin send_idle_pct <= 25; stall_pct <= 25; end
      endcase
   endtask

   localparam logic signed [SW-1:0] S_MIN = {1'b1, {(SW-1){1'b0}}};
   localparam logic signed [SW-1:0] S_MAX = {1'b0, {(SW-1){1'b1}}};

   int phase_sizes [20] = '{0, 1, 2, 16, 31, 17, 3, 4, 5, 7, 8, 9, 10, 11, 12, 13, 14, 15,
                            6, 16};

   initial begin
      tracker       = new();
      window_writes = 0;
      reset        <= 1'b1;
      req_valid    <= 1'b0;
      req_sample   <= '0;
      req_restart  <= 1'b0;
      csr_psel     <= 1'b0;
      csr_penable  <= 1'b0;
      csr_pwrite   <= 1'b0;
      csr_paddr    <= '0;
      csr_pwdata   <= '0;
      send_idle_pct <= 0;
      stall_pct    <= 0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset value of the window register, then directed cases at window 3
      csr_check_window();
      send_sample(S_MIN, 1'b0);
      send_sample(S_MAX, 1'b0);       // window still filling
      send_sample(S_MAX, 1'b0);       // first full window
      send_sample(S_MIN, 1'b0);       // slide
      send_sample(SW'(0), 1'b1);      // restart empties the window
      send_sample(SW'(5), 1'b0);
      send_sample(SW'(5), 1'b0);
      send_sample(SW'(5), 1'b0);      // all equal values
      settle();
      csr_write(REG_UNMAPPED, 32'h0000_0007);   // must leave the window alone
      csr_check_window();
      send_sample(SW'(-1), 1'b0);     // removes only one of the duplicates
      send_sample(SW'(5), 1'b1);

      set_window_size(2);             // even window, extremes of the result
      send_sample(S_MIN, 1'b0);
      send_sample(S_MIN, 1'b0);
      send_sample(S_MAX, 1'b0);
      send_sample(S_MAX, 1'b0);
      set_window_size(0);             // acts as one
      send_sample(SW'(7), 1'b0);
      send_sample(SW'(-7), 1'b1);
      set_window_size(31);            // saturates at the maximum
      for (int i = 0; i < 4; i++)
         send_sample(pick_sample(), 1'b0);

      foreach (phase_sizes[ph]) begin
         set_window_size(phase_sizes[ph]);
         set_idle_mode(ph);
         for (int i = 0; i < 64; i++) begin
            if (i == 32)
               settle();              // sender holds off until all medians are out
            send_sample(pick_sample(), $urandom_range(99) < 3);
         end
      end

      settle();
      repeat (10) @(posedge clock);
      while (tracker.pending_medians.size() != 0)
         tracker.report_mismatch($sformatf("median %0d never came out",
                                           tracker.pending_medians.pop_front()));

      $display("Covered %0d samples and %0d checked medians over %0d window-size writes,",
               tracker.samples, tracker.medians, window_writes);
      $display("with restarts, duplicates, extremes and mixed idle and stall phases.");
      if (tracker.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
